// ===== rtl/ccpb_pkg.sv =====
// Shared widths and register codes for the clipped coverage pixel blend.
// No dependencies; imported by every module of the block.
package ccpb_pkg;

    // Coordinate width of the native pixel position
    localparam int COORD_BITS = 16;

    // Register field widths
    localparam int EDGE_W  = 12;   // clip_left, clip_top
    localparam int EXT_W   = 13;   // clip_width, clip_height, surface_width
    localparam int SCALE_W = 4;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    // Scaled bounds: edge*scale, (edge+extent)*scale, width*scale
    localparam int LOW_W    = EDGE_W + SCALE_W;
    localparam int HIGH_W   = EXT_W + 1 + SCALE_W;
    localparam int STRIDE_W = EXT_W + SCALE_W;
    localparam int CMP_W    = COORD_BITS + HIGH_W + 1;

    // Address and row product
    localparam int ADDR_W  = 30;
    localparam int PROD_W  = COORD_BITS - 1 + STRIDE_W;
    localparam int ASUM_W  = PROD_W + ADDR_W;

    // Pixel channels
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int MSUM_W  = 2 * CH_W;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT     = 3'd0,
        CFG_CLIP_TOP      = 3'd1,
        CFG_CLIP_WIDTH    = 3'd2,
        CFG_CLIP_HEIGHT   = 3'd3,
        CFG_DISPLAY_SCALE = 3'd4,
        CFG_SURFACE_WIDTH = 3'd5
    } t_cfg_idx;

endpackage

// ===== rtl/ccpb_mix.sv =====
// One color channel mix: ink*a + dest*(255-a), before the divide by 255.
// Depends on ccpb_pkg for the channel widths.
module ccpb_mix
    import ccpb_pkg::*;
(
    input  logic [CH_W-1:0]   i_ink,
    input  logic [CH_W-1:0]   i_dst,
    input  logic [CH_W-1:0]   i_alpha,
    output logic [MSUM_W-1:0] o_sum
);

    logic [CH_W-1:0]   inv_alpha;
    logic [MSUM_W-1:0] ink_term;
    logic [MSUM_W-1:0] dst_term;

    // 255 - a is a plain bit inversion
    assign inv_alpha = ALPHA_FULL - i_alpha;
    assign ink_term  = MSUM_W'(i_ink) * MSUM_W'(i_alpha);
    assign dst_term  = MSUM_W'(i_dst) * MSUM_W'(inv_alpha);

    // Sum stays at or below 255*255, so no carry out
    assign o_sum = ink_term + dst_term;

endmodule

// ===== rtl/clipped_coverage_pixel_blend.sv =====
// Top level of the clipped coverage pixel blend: registers, clip test,
// blend and address pipeline. Depends on ccpb_pkg and ccpb_mix.
//
// Channel | Handshake                  | Payload
// --------+----------------------------+-------------------------------------
// in      | i_in_valid / o_in_stall    | pos_x, pos_y, ink_color, coverage,
//         |                            | dest_pixel
// out     | o_out_valid / i_out_stall  | write_enable, new_pixel,
//         |                            | pixel_address
// cfg     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Three register stages: scaled bounds, then clip compare with the row
// multiply and channel products, then divide by 255 and address add.
// One item per cycle unless the output stalls; o_out_valid is the stage 3 valid bit.
// A stage takes a new item when it is empty or its item moves on, so
// bubbles close up under stall and nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and loads register defaults.
module clipped_coverage_pixel_blend
    import ccpb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic [PIX_W-1:0]             i_ink_color,
    input  logic [CH_W-1:0]              i_coverage,
    input  logic [PIX_W-1:0]             i_dest_pixel,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_write_enable,
    output logic [PIX_W-1:0]             o_new_pixel,
    output logic [ADDR_W-1:0]            o_pixel_address
);

    // Exact floor(v/255) for v up to 255*255: ((v+1)*257) >> 16
    function automatic logic [CH_W-1:0] div255(input logic [MSUM_W-1:0] v);
        logic [MSUM_W:0]     v1;
        logic [MSUM_W+9:0]   t;
        v1 = {1'b0, v} + (MSUM_W+1)'(1);
        t  = ((MSUM_W+10)'(v1) << 8) + (MSUM_W+10)'(v1);
        return t[MSUM_W+CH_W-1:MSUM_W];
    endfunction

    // ---------------- configuration registers ----------------
    logic [EDGE_W-1:0]  r_clip_left, r_clip_top;
    logic [EXT_W-1:0]   r_clip_width, r_clip_height, r_surface_width;
    logic [SCALE_W-1:0] r_display_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left     <= '0;
            r_clip_top      <= '0;
            r_clip_width    <= '0;
            r_clip_height   <= '0;
            r_display_scale <= SCALE_W'(1);
            r_surface_width <= EXT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_LEFT:     r_clip_left     <= i_cfg_data[EDGE_W-1:0];
                CFG_CLIP_TOP:      r_clip_top      <= i_cfg_data[EDGE_W-1:0];
                CFG_CLIP_WIDTH:    r_clip_width    <= i_cfg_data[EXT_W-1:0];
                CFG_CLIP_HEIGHT:   r_clip_height   <= i_cfg_data[EXT_W-1:0];
                CFG_DISPLAY_SCALE: r_display_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_SURFACE_WIDTH: r_surface_width <= i_cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage advance ----------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !r_s3_v || !i_out_stall;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (rdy1) r_s1_v <= i_in_valid;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
        end
    end

    // ---------------- stage 1: capture item, scale clip bounds ----------------
    logic [SCALE_W-1:0] scale;
    logic [LOW_W-1:0]    n_left, n_top;
    logic [HIGH_W-1:0]   n_right, n_bottom;
    logic [STRIDE_W-1:0] n_stride;

    // Zero scale acts as one
    assign scale    = (r_display_scale == '0) ? SCALE_W'(1) : r_display_scale;
    assign n_left   = LOW_W'(r_clip_left) * LOW_W'(scale);
    assign n_top    = LOW_W'(r_clip_top) * LOW_W'(scale);
    assign n_right  = (HIGH_W'(r_clip_left) + HIGH_W'(r_clip_width)) * HIGH_W'(scale);
    assign n_bottom = (HIGH_W'(r_clip_top) + HIGH_W'(r_clip_height)) * HIGH_W'(scale);
    assign n_stride = STRIDE_W'(r_surface_width) * STRIDE_W'(scale);

    logic signed [COORD_BITS-1:0] r_s1_x, r_s1_y;
    logic [PIX_W-1:0]    r_s1_ink, r_s1_dst;
    logic [CH_W-1:0]     r_s1_a;
    logic [LOW_W-1:0]    r_s1_left, r_s1_top;
    logic [HIGH_W-1:0]   r_s1_right, r_s1_bottom;
    logic [STRIDE_W-1:0] r_s1_stride;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_x      <= i_pos_x;
            r_s1_y      <= i_pos_y;
            r_s1_ink    <= i_ink_color;
            r_s1_a      <= i_coverage;
            r_s1_dst    <= i_dest_pixel;
            r_s1_left   <= n_left;
            r_s1_top    <= n_top;
            r_s1_right  <= n_right;
            r_s1_bottom <= n_bottom;
            r_s1_stride <= n_stride;
        end
    end

    // ---------------- stage 2: clip test, row product, channel products -----
    logic signed [CMP_W-1:0] xs, ys;
    logic n_keep;

    assign xs = CMP_W'(r_s1_x);
    assign ys = CMP_W'(r_s1_y);
    assign n_keep = (r_s1_a != '0)
        && (xs >= signed'(CMP_W'(r_s1_left)))
        && (ys >= signed'(CMP_W'(r_s1_top)))
        && (xs <  signed'(CMP_W'(r_s1_right)))
        && (ys <  signed'(CMP_W'(r_s1_bottom)));

    logic [MSUM_W-1:0] n_sum_r, n_sum_g, n_sum_b;

    ccpb_mix u_mix_r (
        .i_ink(r_s1_ink[3*CH_W-1:2*CH_W]), .i_dst(r_s1_dst[3*CH_W-1:2*CH_W]),
        .i_alpha(r_s1_a), .o_sum(n_sum_r)
    );
    ccpb_mix u_mix_g (
        .i_ink(r_s1_ink[2*CH_W-1:CH_W]), .i_dst(r_s1_dst[2*CH_W-1:CH_W]),
        .i_alpha(r_s1_a), .o_sum(n_sum_g)
    );
    ccpb_mix u_mix_b (
        .i_ink(r_s1_ink[CH_W-1:0]), .i_dst(r_s1_dst[CH_W-1:0]),
        .i_alpha(r_s1_a), .o_sum(n_sum_b)
    );

    // y is non-negative whenever the item is kept, so its sign bit drops
    logic [PROD_W-1:0] n_prod;
    assign n_prod = PROD_W'(r_s1_y[COORD_BITS-2:0]) * PROD_W'(r_s1_stride);

    logic                   r_s2_keep;
    logic [MSUM_W-1:0]      r_s2_sum_r, r_s2_sum_g, r_s2_sum_b;
    logic [PROD_W-1:0]      r_s2_prod;
    logic [COORD_BITS-2:0]  r_s2_x;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_keep  <= n_keep;
            r_s2_sum_r <= n_sum_r;
            r_s2_sum_g <= n_sum_g;
            r_s2_sum_b <= n_sum_b;
            r_s2_prod  <= n_prod;
            r_s2_x     <= r_s1_x[COORD_BITS-2:0];
        end
    end

    // ---------------- stage 3: divide by 255, address, output register ------
    logic [ASUM_W-1:0] n_addr_sum;
    assign n_addr_sum = ASUM_W'(r_s2_prod) + ASUM_W'(r_s2_x);

    logic              r_s3_we;
    logic [PIX_W-1:0]  r_s3_pix;
    logic [ADDR_W-1:0] r_s3_addr;

    // Dropped writes report zero pixel and address
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_we <= r_s2_keep;
            if (r_s2_keep) begin
                r_s3_pix  <= {div255(r_s2_sum_r), div255(r_s2_sum_g),
                              div255(r_s2_sum_b)};
                r_s3_addr <= n_addr_sum[ADDR_W-1:0];
            end else begin
                r_s3_pix  <= '0;
                r_s3_addr <= '0;
            end
        end
    end

    assign o_out_valid     = r_s3_v;
    assign o_write_enable  = r_s3_we;
    assign o_new_pixel     = r_s3_pix;
    assign o_pixel_address = r_s3_addr;

endmodule

// ===== rtl/ccpb_checker.sv =====
// Port-level checks for clipped_coverage_pixel_blend, bound to the top level.
// Depends on ccpb_pkg and the top level's ports.
module ccpb_checker
    import ccpb_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_write_enable,
    input  logic [PIX_W-1:0]             o_new_pixel,
    input  logic [ADDR_W-1:0]            o_pixel_address
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty output stage never backs up the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // Dropped writes carry zero fields
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_enable) |->
            (o_new_pixel == '0) && (o_pixel_address == '0))
        else $error("dropped write with nonzero fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_write_enable) && $stable(o_new_pixel)
            && $stable(o_pixel_address))
        else $error("stalled result changed");

endmodule

bind clipped_coverage_pixel_blend ccpb_checker u_ccpb_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_write_enable(o_write_enable),
    .o_new_pixel(o_new_pixel),
    .o_pixel_address(o_pixel_address)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for clipped_coverage_pixel_blend: clip test, coverage blend
// and framebuffer address, checked against a predictor. Depends on ccpb_pkg and the RTL.
module testbench;
    import ccpb_pkg::*;

    localparam int PIPE_LAT       = 3;
    localparam int WATCHDOG_LIMIT = 2000;

    // One pixel request as presented on the input channel
    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [PIX_W-1:0]             ink_color;
        logic [CH_W-1:0]              coverage;
        logic [PIX_W-1:0]             dest_pixel;
        logic                         hold_for_drain;
    } t_pixel_req;

    // One framebuffer write as produced on the output channel
    typedef struct packed {
        logic              write_enable;
        logic [PIX_W-1:0]  new_pixel;
        logic [ADDR_W-1:0] pixel_address;
    } t_fb_write;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [COORD_BITS-1:0] i_pos_x = '0;
    logic signed [COORD_BITS-1:0] i_pos_y = '0;
    logic [PIX_W-1:0]             i_ink_color = '0;
    logic [CH_W-1:0]              i_coverage = '0;
    logic [PIX_W-1:0]             i_dest_pixel = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_write_enable;
    logic [PIX_W-1:0]             o_new_pixel;
    logic [ADDR_W-1:0]            o_pixel_address;

    // Shadow copy of the registers, reset values loaded here
    logic [EDGE_W-1:0]  cfg_clip_left = '0;
    logic [EDGE_W-1:0]  cfg_clip_top = '0;
    logic [EXT_W-1:0]   cfg_clip_width = '0;
    logic [EXT_W-1:0]   cfg_clip_height = '0;
    logic [SCALE_W-1:0] cfg_scale = 1;
    logic [EXT_W-1:0]   cfg_surface_width = 1;

    t_pixel_req pixel_queue[$];
    t_fb_write  expected_writes[$];
    t_pixel_req cur_px;
    int         err_count = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         run_left = 0;
    int         stuck_cycles = 0;
    bit         no_idle = 1'b0;

    clipped_coverage_pixel_blend u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Expected framebuffer write for one pixel under the current registers
    function automatic t_fb_write blend_pixel(t_pixel_req px);
        longint    sc, x, y, left, top, right, bottom, stride, addr_sum;
        int        a, ink_c, dst_c, ch;
        t_fb_write w;
        w = '0;
        sc = (cfg_scale == 0) ? 1 : longint'(cfg_scale);
        x = longint'($signed(px.pos_x));
        y = longint'($signed(px.pos_y));
        a = int'(px.coverage);
        left = longint'(cfg_clip_left) * sc;
        top = longint'(cfg_clip_top) * sc;
        right = (longint'(cfg_clip_left) + longint'(cfg_clip_width)) * sc;
        bottom = (longint'(cfg_clip_top) + longint'(cfg_clip_height)) * sc;
        stride = longint'(cfg_surface_width) * sc;
        if (a == 0 || x < left || y < top || x >= right || y >= bottom)
            return w;
        w.write_enable = 1'b1;
        if (px.coverage == ALPHA_FULL) begin
            w.new_pixel = px.ink_color;
        end else begin
            for (ch = 0; ch < 3; ch++) begin
                ink_c = int'(px.ink_color[ch*CH_W +: CH_W]);
                dst_c = int'(px.dest_pixel[ch*CH_W +: CH_W]);
                w.new_pixel[ch*CH_W +: CH_W] =
                    CH_W'((ink_c * a + dst_c * (int'(ALPHA_FULL) - a)) / int'(ALPHA_FULL));
            end
        end
        addr_sum = y * stride + x;
        w.pixel_address = addr_sum[ADDR_W-1:0];
        return w;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pixel_req mk_px(int x, int y, int ink, int cov, int dest);
        t_pixel_req p;
        p.pos_x = x[COORD_BITS-1:0];
        p.pos_y = y[COORD_BITS-1:0];
        p.ink_color = ink[PIX_W-1:0];
        p.coverage = cov[CH_W-1:0];
        p.dest_pixel = dest[PIX_W-1:0];
        p.hold_for_drain = 1'b0;
        return p;
    endfunction

    // Coordinate near a scaled clip span most of the time, anywhere otherwise
    function automatic int pick_coord(longint lo_edge, longint hi_edge);
        longint lo, hi;
        lo = lo_edge - 2;
        hi = hi_edge + 1;
        if (lo < -32768)
            lo = -32768;
        if (hi > 32767)
            hi = 32767;
        if (lo > hi || $urandom_range(0, 99) < 30)
            return $signed(16'($urandom_range(0, 65535)));
        return int'(lo) + $urandom_range(0, int'(hi - lo));
    endfunction

    function automatic t_pixel_req random_pixel();
        longint     sc;
        int         r, x, y, cov, ink;
        t_pixel_req p;
        sc = (cfg_scale == 0) ? 1 : longint'(cfg_scale);
        x = pick_coord(longint'(cfg_clip_left) * sc,
                       (longint'(cfg_clip_left) + longint'(cfg_clip_width)) * sc);
        y = pick_coord(longint'(cfg_clip_top) * sc,
                       (longint'(cfg_clip_top) + longint'(cfg_clip_height)) * sc);
        r = $urandom_range(0, 99);
        if (r < 10)
            cov = 0;
        else if (r < 25)
            cov = int'(ALPHA_FULL);
        else if (r < 30)
            cov = $urandom_range(0, 1) ? 1 : 254;
        else
            cov = $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 10)
            ink = $urandom_range(0, 1) ? 'hFFFFFF : 0;
        else
            ink = $urandom_range(0, 'hFFFFFF);
        p = mk_px(x, y, ink, cov, $urandom_range(0, 'hFFFFFF));
        p.hold_for_drain = ($urandom_range(0, 199) == 0);
        return p;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        err_count++;
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // Register write on the config port; shadow copy follows
    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_CLIP_LEFT:     cfg_clip_left = value[EDGE_W-1:0];
            CFG_CLIP_TOP:      cfg_clip_top = value[EDGE_W-1:0];
            CFG_CLIP_WIDTH:    cfg_clip_width = value[EXT_W-1:0];
            CFG_CLIP_HEIGHT:   cfg_clip_height = value[EXT_W-1:0];
            CFG_DISPLAY_SCALE: cfg_scale = value[SCALE_W-1:0];
            CFG_SURFACE_WIDTH: cfg_surface_width = value[EXT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned left, int unsigned top, int unsigned w,
                              int unsigned h, int unsigned scale, int unsigned surf);
        write_reg(CFG_CLIP_LEFT, left);
        write_reg(CFG_CLIP_TOP, top);
        write_reg(CFG_CLIP_WIDTH, w);
        write_reg(CFG_CLIP_HEIGHT, h);
        write_reg(CFG_DISPLAY_SCALE, scale);
        write_reg(CFG_SURFACE_WIDTH, surf);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block idle: nothing queued, nothing presented, nothing outstanding
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || i_in_valid || expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Sender: presents queued pixels, holds under stall, random gaps
    always @(posedge i_clk) begin : pixel_driver
        bit in_taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken)
                expected_writes.push_back(blend_pixel(cur_px));
            if (i_in_valid && !in_taken) begin
                // stalled: payload stays put
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0 &&
                         !(pixel_queue[0].hold_for_drain && expected_writes.size() != 0)) begin
                cur_px = pixel_queue.pop_front();
                i_pos_x <= cur_px.pos_x;
                i_pos_y <= cur_px.pos_y;
                i_ink_color <= cur_px.ink_color;
                i_coverage <= cur_px.coverage;
                i_dest_pixel <= cur_px.dest_pixel;
                i_in_valid <= 1'b1;
                send_gap = idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted write, random stall bursts
    always @(posedge i_clk) begin : write_monitor
        t_fb_write want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            run_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected write, address", o_pixel_address, 0);
                end else begin
                    want = expected_writes.pop_front();
                    if (o_write_enable !== want.write_enable)
                        report_mismatch("write_enable", o_write_enable, want.write_enable);
                    if (o_new_pixel !== want.new_pixel)
                        report_mismatch("new_pixel", o_new_pixel, want.new_pixel);
                    if (o_pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", o_pixel_address,
                                        want.pixel_address);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    stall_left = idle_len();
                    run_left = $urandom_range(0, 10);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int p, n, k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: empty clip drops every pixel
        pixel_queue.push_back(mk_px(0, 0, 'hFFFFFF, 255, 0));
        pixel_queue.push_back(mk_px(5, 5, 'h123456, 128, 'h654321));
        pixel_queue.push_back(mk_px(-32768, 32767, 'hFFFFFF, 255, 'hFFFFFF));
        pixel_queue.push_back(mk_px(32767, -1, 0, 1, 0));
        wait_drained();

        // Directed: window x 30..119, y 60..179 at scale 3, stride 300
        set_config(10, 20, 30, 40, 3, 100);
        pixel_queue.push_back(mk_px(30, 60, 'hFFFFFF, 255, 0));
        pixel_queue.push_back(mk_px(119, 179, 0, 255, 'hFFFFFF));
        pixel_queue.push_back(mk_px(29, 100, 'h123456, 255, 0));
        pixel_queue.push_back(mk_px(120, 100, 'h123456, 255, 0));
        pixel_queue.push_back(mk_px(50, 59, 'h123456, 255, 0));
        pixel_queue.push_back(mk_px(50, 180, 'h123456, 255, 0));
        pixel_queue.push_back(mk_px(50, 100, 'hFFFFFF, 0, 0));
        pixel_queue.push_back(mk_px(50, 100, 'hFFFFFF, 1, 0));
        pixel_queue.push_back(mk_px(50, 100, 'hFFFFFF, 254, 0));
        pixel_queue.push_back(mk_px(50, 100, 0, 128, 'hFFFFFF));
        pixel_queue.push_back(mk_px(60, 70, 'hFF00FF, 200, 'h00FF00));
        pixel_queue.push_back(mk_px(-1, -1, 'hFFFFFF, 255, 0));
        pixel_queue.push_back(mk_px(-32768, -32768, 'hFFFFFF, 255, 'hFFFFFF));
        pixel_queue.push_back(mk_px(32767, 32767, 'hFFFFFF, 255, 'hFFFFFF));
        pixel_queue.push_back(mk_px(100, 32767, 'hAA55AA, 255, 0));
        pixel_queue.push_back(mk_px(0, 0, 'h55AA55, 255, 0));
        wait_drained();

        // Random phases, the first few at the register extremes
        for (p = 0; p < 10; p++) begin
            case (p)
                0: set_config(0, 0, 4096, 4096, 8, 4096);      // wide window, full address range
                1: set_config(100, 50, 64, 32, 0, 0);          // zero scale, zero stride
                2: set_config(4095, 4095, 8191, 8191, 15, 8191); // window beyond coordinates
                3: set_config(0, 0, 0, 4096, 1, 640);          // empty clip
                4: set_config(0, 0, 1, 1, 1, 1);               // single pixel window
                default: begin
                    k = $urandom_range(0, 99);
                    set_config($urandom_range(0, 300), $urandom_range(0, 300),
                               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400),
                               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400),
                               (k < 15) ? 0 : (k < 30) ? $urandom_range(9, 15)
                                                       : $urandom_range(1, 8),
                               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4096));
                end
            endcase
            no_idle = (p == 3 || p == 6);
            n = (p == 2 || p == 3) ? 60 : 240;
            for (k = 0; k < n; k++) begin
                pixel_queue.push_back(random_pixel());
                // sender waits for every outstanding write once per phase
                if (k == n / 2)
                    pixel_queue[pixel_queue.size()-1].hold_for_drain = 1'b1;
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
